// ===== sv/bdq_pkg.sv =====
`default_nettype none
package bdq_pkg;

  localparam int DATA_W = 32;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [ACT_W-1:0] ACT_PUSH_LEFT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_RIGHT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_POP_LEFT   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_POP_RIGHT  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_PUSHED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_POPPED = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

  typedef struct packed {
    logic push_left;
    logic push_right;
    logic pop_left;
    logic pop_right;
  } bdq_op_t;

endpackage
`default_nettype wire

// ===== sv/bounded_double_ended_queue.sv =====
// a result is registered and shown in the cycle after its input transfer
// throughput: one operation per cycle while the result side does not stall
// the entries sit in a row of cells that shift by one on a left push or pop
// reset: queue empty, capacity 16, result register empty
`default_nettype none
module bounded_double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [bdq_pkg::CAP_W-1:0]         cfg_wr_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [bdq_pkg::ACT_W-1:0]         in_action,
  input  wire logic signed [bdq_pkg::DATA_W-1:0] in_push_value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [bdq_pkg::STAT_W-1:0]             out_status,
  output logic signed [bdq_pkg::DATA_W-1:0]      out_item_value
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > bdq_pkg::CAP_W) ? CNT_W : bdq_pkg::CAP_W;

  logic [bdq_pkg::CAP_W-1:0]  cap_r;
  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           count_nxt;
  logic                       out_valid_r;
  logic [bdq_pkg::STAT_W-1:0] status_r;
  logic [bdq_pkg::STAT_W-1:0] status_nxt;
  logic [bdq_pkg::DATA_W-1:0] value_r;
  logic [bdq_pkg::DATA_W-1:0] value_nxt;

  logic                       take;
  logic                       full;
  logic                       empty;
  bdq_pkg::bdq_op_t           op;
  logic [bdq_pkg::DATA_W-1:0] tail_value;

  logic                       occ_w  [DEPTH];
  logic [bdq_pkg::DATA_W-1:0] data_w [DEPTH];
  logic [bdq_pkg::DATA_W-1:0] tail_w [DEPTH];

  assign in_stall       = out_valid_r & out_stall;
  assign take           = in_valid & ~in_stall;
  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_item_value = value_r;

  assign empty = ~occ_w[0];
  assign full  = occ_w[DEPTH-1] | (CMP_W'(count_r) >= CMP_W'(cap_r));

  always_comb begin
    op.push_left  = take & (in_action == bdq_pkg::ACT_PUSH_LEFT) & ~full;
    op.push_right = take & (in_action == bdq_pkg::ACT_PUSH_RIGHT) & ~full;
    op.pop_left   = take & (in_action == bdq_pkg::ACT_POP_LEFT) & ~empty;
    op.pop_right  = take & (in_action == bdq_pkg::ACT_POP_RIGHT) & ~empty;
  end

  always_comb begin
    tail_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_value = tail_value | tail_w[i];
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic                       l_occ;
      logic [bdq_pkg::DATA_W-1:0] l_data;
      logic                       r_occ;
      logic [bdq_pkg::DATA_W-1:0] r_data;
      if (g == 0) begin : g_first
        assign l_occ  = 1'b1;
        assign l_data = in_push_value;
      end else begin : g_mid_l
        assign l_occ  = occ_w[g-1];
        assign l_data = data_w[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign r_occ  = 1'b0;
        assign r_data = '0;
      end else begin : g_mid_r
        assign r_occ  = occ_w[g+1];
        assign r_data = data_w[g+1];
      end
      bdq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .push_value (in_push_value),
        .left_occ   (l_occ),
        .left_data  (l_data),
        .right_occ  (r_occ),
        .right_data (r_data),
        .occ        (occ_w[g]),
        .data       (data_w[g]),
        .tail_data  (tail_w[g])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (op.push_left || op.push_right) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (op.pop_left || op.pop_right) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    status_nxt = bdq_pkg::STAT_EMPTY;
    value_nxt  = '0;
    case (in_action)
      bdq_pkg::ACT_PUSH_LEFT, bdq_pkg::ACT_PUSH_RIGHT: begin
        if (full) begin
          status_nxt = bdq_pkg::STAT_FULL;
        end else begin
          status_nxt = bdq_pkg::STAT_PUSHED;
          value_nxt  = in_push_value;
        end
      end
      bdq_pkg::ACT_POP_LEFT: begin
        if (!empty) begin
          status_nxt = bdq_pkg::STAT_POPPED;
          value_nxt  = data_w[0];
        end
      end
      bdq_pkg::ACT_POP_RIGHT: begin
        if (!empty) begin
          status_nxt = bdq_pkg::STAT_POPPED;
          value_nxt  = tail_value;
        end
      end
      default: begin
        status_nxt = bdq_pkg::STAT_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= bdq_pkg::CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      count_r <= count_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (take) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/bdq_cell.sv =====
`default_nettype none
module bdq_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bdq_pkg::bdq_op_t            op,
  input  wire logic [bdq_pkg::DATA_W-1:0]  push_value,
  input  wire logic                        left_occ,
  input  wire logic [bdq_pkg::DATA_W-1:0]  left_data,
  input  wire logic                        right_occ,
  input  wire logic [bdq_pkg::DATA_W-1:0]  right_data,
  output logic                             occ,
  output logic [bdq_pkg::DATA_W-1:0]       data,
  output logic [bdq_pkg::DATA_W-1:0]       tail_data
);

  logic                       occ_r;
  logic                       occ_nxt;
  logic [bdq_pkg::DATA_W-1:0] data_r;
  logic [bdq_pkg::DATA_W-1:0] data_nxt;
  logic                       is_tail;

  assign is_tail   = occ_r & ~right_occ;
  assign occ       = occ_r;
  assign data      = data_r;
  assign tail_data = is_tail ? data_r : '0;

  always_comb begin
    occ_nxt  = occ_r;
    data_nxt = data_r;
    if (op.push_left) begin
      occ_nxt  = left_occ;
      data_nxt = left_data;
    end else if (op.push_right) begin
      if (!occ_r && left_occ) begin
        occ_nxt  = 1'b1;
        data_nxt = push_value;
      end
    end else if (op.pop_left) begin
      occ_nxt  = right_occ;
      data_nxt = right_data;
    end else if (op.pop_right) begin
      if (is_tail) begin
        occ_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
    data_r <= data_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/bdq_checker.sv =====
`default_nettype none
module bdq_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [bdq_pkg::STAT_W-1:0]   out_status,
  input wire logic [bdq_pkg::DATA_W-1:0]   out_item_value
);

  // result register empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // each input transfer shows a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("input transfer gave no result");

  // input only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // refused operations carry zero
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == bdq_pkg::STAT_FULL || out_status == bdq_pkg::STAT_EMPTY)
    |-> out_item_value == '0)
    else $error("refused operation with nonzero value");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_item_value))
    else $error("stalled result changed");

endmodule

bind bounded_double_ended_queue bdq_checker u_bdq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_item_value (out_item_value)
);
`default_nettype wire
